### sv/ecal_pkg.sv
package ecal_pkg;

    // Pipeline depth: one register stage per entry of the enable vector
    localparam int unsigned STAGES = 10;

    typedef logic [STAGES-1:0] t_en;

    // Field widths
    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned ZONE_W  = 17;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned OUT_W   = 40;

    // Reset zone offset: nine hours
    localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd32400;

    // Reciprocals for division by constants (multiply, then shift)
    localparam logic [25:0] RCP_675  = 26'd50903317;  // x < 2^25, shift 35
    localparam logic [16:0] RCP_365A = 17'd91930;     // x < 2^16, shift 25
    localparam logic [18:0] RCP_365B = 19'd367720;    // x < 2^18, shift 27
    localparam logic [11:0] RCP_153  = 12'd3427;      // x < 2^11, shift 19
    localparam logic [13:0] RCP_225  = 14'd9321;      // x < 2^13, shift 21
    localparam logic [10:0] RCP_15   = 11'd1093;      // x < 2^10, shift 14

    // Day counts on the shifted (March-based) calendar
    localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;
    localparam logic [19:0] ERA4_START    = 20'd584388;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
    } t_date;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic              clamped;
    } t_tod;

    // First day of month index mp (March = 0) within the shifted year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### sv/ecal_split.sv
module ecal_split
    import ecal_pkg::*;
(
    input  logic                i_clk,
    input  t_en                 i_en,
    input  logic [EPOCH_W-1:0]  i_epoch,
    input  logic [ZONE_W-1:0]   i_zone,
    output logic [15:0]         o_days,
    output logic [16:0]         o_rem,
    output logic                o_clamped
);

    logic [33:0] w_sum;
    logic        w_neg;
    logic        w_over;

    logic [31:0] r_t0, n_t0;
    logic        r_c0, n_c0;
    logic [50:0] r_p1, n_p1;
    logic [16:0] r_tlo1;
    logic        r_c1;
    logic [15:0] r_days2, n_days2;
    logic [16:0] r_rem2, n_rem2;
    logic        r_c2;
    logic [32:0] w_dmul;

    // Stage 0: add zone offset, clamp to 32-bit range
    assign w_sum  = {2'b00, i_epoch} + {{17{i_zone[ZONE_W-1]}}, i_zone};
    assign w_neg  = w_sum[33];
    assign w_over = ~w_sum[33] & w_sum[32];
    assign n_t0   = w_neg ? 32'd0 : (w_over ? 32'hFFFF_FFFF : w_sum[31:0]);
    assign n_c0   = w_neg | w_over;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t0 <= n_t0;
            r_c0 <= n_c0;
        end
    end

    // Stage 1: t / 86400 = (t >> 7) / 675 by reciprocal
    assign n_p1 = {26'd0, r_t0[31:7]} * {25'd0, RCP_675};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p1   <= n_p1;
            r_tlo1 <= r_t0[16:0];
            r_c1   <= r_c0;
        end
    end

    // Stage 2: day count and seconds within the day
    assign n_days2 = r_p1[50:35];
    assign w_dmul  = {17'd0, n_days2} * 33'd86400;
    assign n_rem2  = r_tlo1 - w_dmul[16:0];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_days2 <= n_days2;
            r_rem2  <= n_rem2;
            r_c2    <= r_c1;
        end
    end

    assign o_days    = r_days2;
    assign o_rem     = r_rem2;
    assign o_clamped = r_c2;

endmodule

### sv/ecal_date.sv
module ecal_date
    import ecal_pkg::*;
(
    input  logic        i_clk,
    input  t_en         i_en,
    input  logic [15:0] i_days,
    output t_date       o_date
);

    logic [19:0] w_z;
    logic        n_hi3;
    logic [17:0] n_doe3;
    logic [17:0] r_doe3;
    logic        r_hi3;

    logic [32:0] n_pq4, r_pq4;
    logic [2:0]  n_q36524, r_q36524;
    logic        n_q146096, r_q146096;
    logic [17:0] r_doe4;
    logic        r_hi4;

    logic [17:0] n_num5, r_num5;
    logic [17:0] r_doe5;
    logic        r_hi5;

    logic [36:0] n_py6, r_py6;
    logic [17:0] r_doe6;
    logic        r_hi6;

    logic [8:0]  n_yoe7, r_yoe7;
    logic [8:0]  n_doy7, r_doy7;
    logic [1:0]  w_c100;
    logic [17:0] w_ybase;
    logic [17:0] w_doy_full;
    logic        r_hi7;

    logic [10:0] w_mp_num;
    logic [22:0] n_pmp8, r_pmp8;
    logic [8:0]  r_doy8;
    logic [8:0]  r_yoe8;
    logic        r_hi8;

    logic [3:0]  w_mp;
    logic [8:0]  w_dom_full;
    t_date       n_out9, r_out9;

    // Stage 3: shift to March-based days, pick the 400-year era
    assign w_z    = {4'd0, i_days} + DAYS_TO_EPOCH;
    assign n_hi3  = (w_z >= ERA5_START);
    assign n_doe3 = n_hi3 ? 18'(w_z - ERA5_START) : 18'(w_z - ERA4_START);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_doe3 <= n_doe3;
            r_hi3  <= n_hi3;
        end
    end

    // Stage 4: doe / 1460 by reciprocal, century counts by compare
    assign n_pq4 = {17'd0, r_doe3[17:2]} * {16'd0, RCP_365A};
    always_comb begin
        if (r_doe3 >= 18'd146096)      n_q36524 = 3'd4;
        else if (r_doe3 >= 18'd109572) n_q36524 = 3'd3;
        else if (r_doe3 >= 18'd73048)  n_q36524 = 3'd2;
        else if (r_doe3 >= 18'd36524)  n_q36524 = 3'd1;
        else                           n_q36524 = 3'd0;
    end
    assign n_q146096 = (r_doe3 == 18'd146096);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_pq4     <= n_pq4;
            r_q36524  <= n_q36524;
            r_q146096 <= n_q146096;
            r_doe4    <= r_doe3;
            r_hi4     <= r_hi3;
        end
    end

    // Stage 5: leap-day corrected day count
    assign n_num5 = r_doe4 - {10'd0, r_pq4[32:25]} + {15'd0, r_q36524}
                    - {17'd0, r_q146096};

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_num5 <= n_num5;
            r_doe5 <= r_doe4;
            r_hi5  <= r_hi4;
        end
    end

    // Stage 6: year of era = num / 365 by reciprocal
    assign n_py6 = {19'd0, r_num5} * {18'd0, RCP_365B};

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_py6  <= n_py6;
            r_doe6 <= r_doe5;
            r_hi6  <= r_hi5;
        end
    end

    // Stage 7: day of the shifted year
    assign n_yoe7 = r_py6[35:27];
    always_comb begin
        if (n_yoe7 >= 9'd300)      w_c100 = 2'd3;
        else if (n_yoe7 >= 9'd200) w_c100 = 2'd2;
        else if (n_yoe7 >= 9'd100) w_c100 = 2'd1;
        else                       w_c100 = 2'd0;
    end
    assign w_ybase    = 18'({9'd0, n_yoe7} * 18'd365) + {11'd0, n_yoe7[8:2]}
                        - {16'd0, w_c100};
    assign w_doy_full = r_doe6 - w_ybase;
    assign n_doy7     = w_doy_full[8:0];

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_yoe7 <= n_yoe7;
            r_doy7 <= n_doy7;
            r_hi7  <= r_hi6;
        end
    end

    // Stage 8: month index = (5 * doy + 2) / 153 by reciprocal
    assign w_mp_num = {r_doy7, 2'b00} + {2'd0, r_doy7} + 11'd2;
    assign n_pmp8   = {12'd0, w_mp_num} * {11'd0, RCP_153};

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_pmp8 <= n_pmp8;
            r_doy8 <= r_doy7;
            r_yoe8 <= r_yoe7;
            r_hi8  <= r_hi7;
        end
    end

    // Stage 9: month, day of month, year
    assign w_mp       = r_pmp8[22:19];
    assign w_dom_full = r_doy8 - month_start(w_mp) + 9'd1;
    always_comb begin
        n_out9.dom   = w_dom_full[DOM_W-1:0];
        n_out9.month = (w_mp < 4'd10) ? (w_mp + 4'd3) : (w_mp - 4'd9);
        n_out9.year  = {3'd0, r_yoe8} + (r_hi8 ? 12'd2000 : 12'd1600)
                       + ((n_out9.month <= 4'd2) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_out9 <= n_out9;
        end
    end

    assign o_date = r_out9;

endmodule

### sv/ecal_time.sv
module ecal_time
    import ecal_pkg::*;
(
    input  logic        i_clk,
    input  t_en         i_en,
    input  logic [16:0] i_rem,
    input  logic        i_clamped,
    output t_tod        o_tod
);

    logic [26:0] n_ph3, r_ph3;
    logic [16:0] r_rem3;
    logic        r_c3;

    logic [4:0]  n_hour4, r_hour4;
    logic [16:0] w_hmul;
    logic [16:0] w_r4_full;
    logic [11:0] n_r4, r_r4;
    logic        r_c4;

    logic [20:0] n_pm5, r_pm5;
    logic [11:0] r_r5;
    logic [4:0]  r_hour5;
    logic        r_c5;

    t_tod        n_tod6;
    logic [11:0] w_smul;
    logic [11:0] w_sec_full;
    t_tod        r_tod6, r_tod7, r_tod8, r_tod9;

    // Stage 3: hour = (rem >> 4) / 225 by reciprocal
    assign n_ph3 = {14'd0, i_rem[16:4]} * {13'd0, RCP_225};

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_ph3  <= n_ph3;
            r_rem3 <= i_rem;
            r_c3   <= i_clamped;
        end
    end

    // Stage 4: seconds within the hour
    assign n_hour4   = r_ph3[25:21];
    assign w_hmul    = {12'd0, n_hour4} * 17'd3600;
    assign w_r4_full = r_rem3 - w_hmul;
    assign n_r4      = w_r4_full[11:0];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_hour4 <= n_hour4;
            r_r4    <= n_r4;
            r_c4    <= r_c3;
        end
    end

    // Stage 5: minute = (r >> 2) / 15 by reciprocal
    assign n_pm5 = {11'd0, r_r4[11:2]} * {10'd0, RCP_15};

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_pm5   <= n_pm5;
            r_r5    <= r_r4;
            r_hour5 <= r_hour4;
            r_c5    <= r_c4;
        end
    end

    // Stage 6: minute and second
    assign w_smul     = {6'd0, r_pm5[19:14]} * 12'd60;
    assign w_sec_full = r_r5 - w_smul;
    always_comb begin
        n_tod6.hour    = r_hour5;
        n_tod6.minute  = r_pm5[19:14];
        n_tod6.second  = w_sec_full[SEC_W-1:0];
        n_tod6.clamped = r_c5;
    end

    // Stages 6 to 9: align with the date path
    always_ff @(posedge i_clk) begin
        if (i_en[6]) r_tod6 <= n_tod6;
        if (i_en[7]) r_tod7 <= r_tod6;
        if (i_en[8]) r_tod8 <= r_tod7;
        if (i_en[9]) r_tod9 <= r_tod8;
    end

    assign o_tod = r_tod9;

endmodule

### sv/epoch_seconds_to_calendar_top.sv
// Epoch seconds to local Gregorian calendar date and time.
//
// Input stream: one request per accepted beat, tdata[31:0] = epoch seconds
// (unsigned, seconds since 1970-01-01 00:00:00 UTC).
// Output stream: one result per request, in order. tdata fields from bit 0:
// year[11:0], month[15:12], day of month[20:16], hour[25:21], minute[31:26],
// second[37:32], clamped[38], zero[39].
// Config channel: i_cfg_data is the signed 17-bit zone offset in seconds,
// added to the epoch count; o_cfg_ready is always high. Write it only while
// no request is in flight.
// The pipe has ten register stages. Every stage can advance each cycle
// while the receiver is ready, so one request per cycle is sustained.
// Local time below 0 or above 2^32-1 is pinned to that limit and flagged.
// Reset clears all stage valid bits and loads a zone offset of +9 hours.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles close up and input is taken until the pipe is full.
module epoch_seconds_to_calendar_top
    import ecal_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [EPOCH_W-1:0]    i_s_axis_tdata,   // epoch_seconds[31:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_W-1:0]      o_m_axis_tdata,   // year, month, day_of_month,
                                                    // hour, minute, second, clamped
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ZONE_W-1:0]     i_cfg_data        // zone_offset_seconds
);

    logic [ZONE_W-1:0] r_zone;
    logic [STAGES-1:0] r_vld;
    t_en               w_en;
    logic [15:0]       w_days;
    logic [16:0]       w_rem;
    logic              w_clamped;
    t_date             w_date;
    t_tod              w_tod;

    // Zone offset register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_zone <= i_cfg_data;
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[STAGES-1] = ~r_vld[STAGES-1] | i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    ecal_split u_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_epoch   (i_s_axis_tdata),
        .i_zone    (r_zone),
        .o_days    (w_days),
        .o_rem     (w_rem),
        .o_clamped (w_clamped)
    );

    ecal_date u_date (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (w_days),
        .o_date (w_date)
    );

    ecal_time u_time (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_rem     (w_rem),
        .i_clamped (w_clamped),
        .o_tod     (w_tod)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = {1'b0, w_tod.clamped, w_tod.second, w_tod.minute,
                              w_tod.hour, w_date.dom, w_date.month, w_date.year};

endmodule

### sv/ecal_check.sv
module ecal_check
    import ecal_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_W-1:0]      o_m_axis_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // An empty output stage never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

    // Month, day of month (lower bound) and time of day in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[15:12] >= 4'd1 && o_m_axis_tdata[15:12] <= 4'd12 &&
            o_m_axis_tdata[20:16] >= 5'd1 && o_m_axis_tdata[25:21] <= 5'd23 &&
            o_m_axis_tdata[31:26] <= 6'd59 && o_m_axis_tdata[37:32] <= 6'd59)
        else $error("calendar field out of range");

    // A clamped result is one of the two range limits
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[38] |->
            (o_m_axis_tdata[37:0] == {6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970}) ||
            (o_m_axis_tdata[37:0] == {6'd15, 6'd28, 5'd6, 5'd7, 4'd2, 12'd2106}))
        else $error("clamped result not at a limit");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind epoch_seconds_to_calendar_top ecal_check u_check (.*);
